### design/swmc_pkg.sv
// Shared constants and control types for the sliding window median cost block.
package swmc_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COST_BITS = 22;
	localparam int CFG_BITS = 7;
	localparam int WINDOW_SIZE_RESET = 3;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;   // sorted insert of the new sample
		logic del;   // drop the oldest sample, close the gap
		logic eval;  // capture |value - median|
	} swmc_ctl_t;

endpackage

### design/swmc_cell.sv
// One slot of the sorted window: value, age and its deviation from the median.
module swmc_cell #(
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF,
	parameter int AGE_W = 6
) (
	input  logic                   clk,
	input  swmc_pkg::swmc_ctl_t    ctl,
	input  logic                   live,
	input  logic                   size_live,
	input  logic [SAMPLE_BITS-1:0] new_val,
	input  logic [SAMPLE_BITS-1:0] left_val,
	input  logic [AGE_W-1:0]       left_age,
	input  logic                   left_gt,
	input  logic [SAMPLE_BITS-1:0] right_val,
	input  logic [AGE_W-1:0]       right_age,
	input  logic [SAMPLE_BITS-1:0] med_val,
	input  logic [SAMPLE_BITS-1:0] old_val,
	output logic [SAMPLE_BITS-1:0] val,
	output logic [AGE_W-1:0]       age,
	output logic                   gt,
	output logic [SAMPLE_BITS-1:0] diff
);

	logic [SAMPLE_BITS-1:0] val_q;
	logic [AGE_W-1:0]       age_q;
	logic [SAMPLE_BITS-1:0] diff_q;

	assign gt = live && (val_q > new_val);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			// equal values stay left of the new one, so older copies come first
			if (live && !gt) begin
				age_q <= age_q + AGE_W'(1);
			end else if (left_gt) begin
				val_q <= left_val;
				age_q <= left_age + AGE_W'(1);
			end else begin
				val_q <= new_val;
				age_q <= '0;
			end
		end else if (ctl.del) begin
			// first slot holding the oldest value is the oldest copy of it
			if (val_q >= old_val) begin
				val_q <= right_val;
				age_q <= right_age;
			end
		end
		if (ctl.eval) begin
			if (!size_live)
				diff_q <= '0;
			else if (val_q >= med_val)
				diff_q <= val_q - med_val;
			else
				diff_q <= med_val - val_q;
		end
	end

	assign val  = val_q;
	assign age  = age_q;
	assign diff = diff_q;

endmodule

### design/swmc_sum_tree.sv
// Registered binary adder tree, one register per level.
module swmc_sum_tree #(
	parameter int N = 64,
	parameter int DW = 16,
	parameter int SW = 22
) (
	input  logic            clk,
	input  logic [N*DW-1:0] leaves,
	output logic [SW-1:0]   root
);

	localparam int P = 1 << $clog2(N);

	logic [SW-1:0] node_v [0:2*P-2];
	logic [SW-1:0] node_q [0:P-2];

	genvar j;
	generate
		for (j = 0; j < 2*P-1; j++) begin : g_node
			if (j < P-1) begin : g_inner
				always_ff @(posedge clk) begin
					node_q[j] <= node_v[2*j+1] + node_v[2*j+2];
				end
				assign node_v[j] = node_q[j];
			end else if (j - (P-1) < N) begin : g_leaf
				assign node_v[j] = SW'(leaves[(j-(P-1))*DW +: DW]);
			end else begin : g_pad
				assign node_v[j] = '0;
			end
		end
	endgenerate

	assign root = node_v[0];

endmodule

### design/sliding_window_median_cost_core.sv
// Sliding window median cost: sequencer, chain of sorted cells and adder tree.
// Flow: an item that fills the window steps through SEL, EVAL, SUM and PUT; SUM
//   waits for the LEVELS = clog2(WINDOW_MAX) adder tree levels and PUT loads the cost.
// Input: an item with no result frees the input for the next; otherwise in_stall holds
//   until PUT, which waits on output stall, is done. Input is taken while a cost waits.
// Reset: window empty, window size 3 (WINDOW_MAX if smaller); cell contents are not cleared.
module sliding_window_median_cost_core #(
	parameter int WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          window_size_we,
	input  logic [swmc_pkg::CFG_BITS-1:0] window_size,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          last_in_sequence,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [swmc_pkg::COST_BITS-1:0] cost
);

	localparam int AGE_W = $clog2(WINDOW_MAX);
	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int LEVELS = $clog2(WINDOW_MAX);
	localparam int SUM_W = SAMPLE_BITS + LEVELS;
	localparam int CNT_W = $clog2(LEVELS) + 1;
	localparam int K_RESET = (swmc_pkg::WINDOW_SIZE_RESET > WINDOW_MAX) ?
		WINDOW_MAX : swmc_pkg::WINDOW_SIZE_RESET;

	typedef enum logic [2:0] {IDLE, SEL, EVAL, SUM, PUT} state_t;

	state_t                  state_q;
	logic [KW-1:0]           k_q;
	logic [KW-1:0]           fill_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [swmc_pkg::COST_BITS-1:0] cost_q;
	logic [SAMPLE_BITS-1:0]  med_q;
	logic [SAMPLE_BITS-1:0]  old_q;

	swmc_pkg::swmc_ctl_t     ctl;
	logic                    in_acc;
	logic                    out_acc;
	logic [KW-1:0]           fill_inc;
	logic [KW-1:0]           k_new;
	logic [AGE_W-1:0]        k_last;
	logic [AGE_W-1:0]        med_idx;

	logic [SAMPLE_BITS-1:0]  cell_val [WINDOW_MAX];
	logic [AGE_W-1:0]        cell_age [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]   cell_gt;
	logic [WINDOW_MAX-1:0]   live;
	logic [WINDOW_MAX-1:0]   size_live;
	logic [WINDOW_MAX-1:0]   old_hit;
	logic [WINDOW_MAX-1:0]   med_hit;
	logic [WINDOW_MAX*SAMPLE_BITS-1:0] leaves;
	logic [SAMPLE_BITS-1:0]  old_sel;
	logic [SAMPLE_BITS-1:0]  med_sel;
	logic [SUM_W-1:0]        root;

	assign in_stall  = (state_q != IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign cost      = cost_q;
	assign fill_inc  = fill_q + KW'(1);
	assign k_last    = AGE_W'(k_q - KW'(1));
	assign med_idx   = k_last >> 1;

	assign ctl.ins  = in_acc;
	assign ctl.del  = (state_q == EVAL);
	assign ctl.eval = (state_q == EVAL);

	always_comb begin
		if (window_size == '0)
			k_new = KW'(1);
		else if (int'(window_size) > WINDOW_MAX)
			k_new = KW'(WINDOW_MAX);
		else
			k_new = KW'(window_size);
	end

	genvar i;
	generate
		for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
			logic [SAMPLE_BITS-1:0] l_val;
			logic [AGE_W-1:0]       l_age;
			logic                   l_gt;
			logic [SAMPLE_BITS-1:0] r_val;
			logic [AGE_W-1:0]       r_age;

			if (i == 0) begin : g_first
				assign l_val = '0;
				assign l_age = '0;
				assign l_gt  = 1'b0;
			end else begin : g_mid
				assign l_val = cell_val[i-1];
				assign l_age = cell_age[i-1];
				assign l_gt  = cell_gt[i-1];
			end
			if (i == WINDOW_MAX-1) begin : g_end
				assign r_val = '0;
				assign r_age = '0;
			end else begin : g_body
				assign r_val = cell_val[i+1];
				assign r_age = cell_age[i+1];
			end

			assign live[i]      = KW'(i) < fill_q;
			assign size_live[i] = KW'(i) < k_q;
			assign old_hit[i]   = size_live[i] && (cell_age[i] == k_last);
			assign med_hit[i]   = (AGE_W'(i) == med_idx);

			swmc_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.AGE_W(AGE_W)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.live     (live[i]),
				.size_live(size_live[i]),
				.new_val  (sample),
				.left_val (l_val),
				.left_age (l_age),
				.left_gt  (l_gt),
				.right_val(r_val),
				.right_age(r_age),
				.med_val  (med_q),
				.old_val  (old_q),
				.val      (cell_val[i]),
				.age      (cell_age[i]),
				.gt       (cell_gt[i]),
				.diff     (leaves[i*SAMPLE_BITS +: SAMPLE_BITS])
			);
		end
	endgenerate

	// one-hot picks: oldest sample and lower median
	always_comb begin
		old_sel = '0;
		med_sel = '0;
		for (int n = 0; n < WINDOW_MAX; n++) begin
			old_sel = old_sel | (old_hit[n] ? cell_val[n] : '0);
			med_sel = med_sel | (med_hit[n] ? cell_val[n] : '0);
		end
	end

	swmc_sum_tree #(
		.N (WINDOW_MAX),
		.DW(SAMPLE_BITS),
		.SW(SUM_W)
	) u_tree (
		.clk   (clk),
		.leaves(leaves),
		.root  (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			k_q         <= KW'(K_RESET);
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == PUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
			if (window_size_we) begin
				k_q    <= k_new;
				fill_q <= '0;
			end
			case (state_q)
				IDLE: begin
					if (in_acc) begin
						if (last_in_sequence)
							fill_q <= '0;
						else if (fill_inc != k_q)
							fill_q <= fill_inc;
						if (fill_inc == k_q)
							state_q <= SEL;
					end
				end
				SEL: begin
					med_q   <= med_sel;
					old_q   <= old_sel;
					state_q <= EVAL;
				end
				EVAL: begin
					cnt_q   <= '0;
					state_q <= SUM;
				end
				SUM: begin
					if (cnt_q == CNT_W'(LEVELS - 1))
						state_q <= PUT;
					else
						cnt_q <= cnt_q + CNT_W'(1);
				end
				PUT: begin
					if (!out_valid_q || !out_stall) begin
						cost_q  <= swmc_pkg::COST_BITS'(root);
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < k_q)
		else $error("window fill reached window size");

	a_full_starts_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fill_inc == k_q) |=> (state_q == SEL))
		else $error("full window did not start evaluation");

	a_oldest_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEL) |-> $onehot(old_hit))
		else $error("cell ages do not mark exactly one oldest sample");

	a_put_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PUT && !out_valid_q) |=> out_valid)
		else $error("cost not loaded into free output slot");

endmodule
